FILE: rtl/prq_pkg.sv
// shared constants and types for the priority run queue scheduler
// no dependencies
`timescale 1ns / 1ps
package prq_pkg;
  localparam int Levels = 64;
  localparam int Threads = 64;
  localparam int LvlW = $clog2(Levels);
  localparam int TidW = $clog2(Threads);
  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgAdd = 32'd12345;
  localparam logic [15:0] ThreshReset = 16'h2000;
  localparam logic [31:0] SeedReset = 32'd871223;
  localparam logic [1:0] CfgThresh = 2'd0;
  localparam logic [1:0] CfgSeed = 2'd1;
  localparam logic [1:0] CfgBoot = 2'd2;
  localparam logic ActEnq = 1'b0;

  typedef struct packed {
    logic       action;
    logic [5:0] thread_id;
    logic signed [7:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic       switched;
    logic [5:0] running_thread;
    logic [5:0] previous_thread;
  } out_word_t;
endpackage

FILE: rtl/prq_if.sv
// valid/ready channel carrying one word of a given type
// depends on prq_pkg for the word types
`timescale 1ns / 1ps
interface prq_in_if (input logic clk);
  logic valid;
  logic ready;
  prq_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prq_out_if (input logic clk);
  logic valid;
  logic ready;
  prq_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/prq_ram.sv
// generic single write, single registered read ram
// no dependencies
`timescale 1ns / 1ps
module prq_ram #(
  parameter int Width = 6,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/priority_run_queue_scheduler_top.sv
// priority run queue scheduler: sequencer, level scan and linked queues
// depends on prq_pkg, prq_if and prq_ram
// enqueue: once the input word is accepted, S_ENQ_R reads the tail, S_ENQ_W appends and
// S_OUT registers the result; reschedule: levels are scanned from the top, one shared lcg
// multiply per non-empty level, dequeue and requeue on a pick, then S_OUT registers the
// result; one word at a time, input ready again once the result word is taken
// synchronous active-low reset clears queue flags, running thread, fsm; heads,
// tails and links stay unknown until written
`timescale 1ns / 1ps
module priority_run_queue_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  prq_in_if.sink      in_ch,
  prq_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int LW = prq_pkg::LvlW;
  localparam int TW = prq_pkg::TidW;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_ENQ_R = 12'b000000000010,
    S_ENQ_W = 12'b000000000100,
    S_SCAN  = 12'b000000001000,
    S_MUL   = 12'b000000010000,
    S_CMP   = 12'b000000100000,
    S_DQ_R  = 12'b000001000000,
    S_DQ_L  = 12'b000010000000,
    S_DQ_W  = 12'b000100000000,
    S_RQ_R  = 12'b001000000000,
    S_RQ_W  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] thresh_r;
  logic [31:0] rnd_r, prod_r;
  logic [LW-1:0] cur_pri_r, lvl_r, app_lvl_r;
  logic [TW-1:0] cur_r, prev_r, app_tid_r, pick_r;
  logic [prq_pkg::Levels-1:0] nonempty_r;
  logic lvl_done_r;
  prq_pkg::out_word_t res_r;
  logic out_v_r;

  // head/tail/link rams
  logic head_we, tail_we, link_we;
  logic [LW-1:0] head_wa, tail_wa, lvl_ra;
  logic [TW-1:0] head_wd, tail_wd, link_wa, link_wd, link_ra;
  logic [TW-1:0] head_rd, tail_rd, link_rd;

  prq_ram #(.Width(TW), .Depth(prq_pkg::Levels)) u_head (.clk, .we(head_we),
    .waddr(head_wa), .wdata(head_wd), .raddr(lvl_ra), .rdata(head_rd));
  prq_ram #(.Width(TW), .Depth(prq_pkg::Levels)) u_tail (.clk, .we(tail_we),
    .waddr(tail_wa), .wdata(tail_wd), .raddr(lvl_ra), .rdata(tail_rd));
  prq_ram #(.Width(TW), .Depth(prq_pkg::Threads)) u_link (.clk, .we(link_we),
    .waddr(link_wa), .wdata(link_wd), .raddr(link_ra), .rdata(link_rd));

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = res_r;

  logic signed [7:0] preq;
  logic [LW-1:0] clamp_lvl;
  assign preq = in_ch.data.priority_req;
  always_comb begin
    if (preq < 0) clamp_lvl = '0;
    else if (preq > 8'sd63) clamp_lvl = LW'(prq_pkg::Levels - 1);
    else clamp_lvl = preq[LW-1:0];
  end

  logic [14:0] draw;
  logic [31:0] rnd_new;
  assign rnd_new = prod_r + prq_pkg::LcgAdd;
  assign draw = rnd_new[30:16];

  always_comb begin
    state_nxt = state_r;
    head_we = 1'b0; tail_we = 1'b0; link_we = 1'b0;
    head_wa = app_lvl_r; tail_wa = app_lvl_r; head_wd = app_tid_r; tail_wd = app_tid_r;
    link_wa = tail_rd; link_wd = app_tid_r;
    lvl_ra = app_lvl_r; link_ra = head_rd;
    case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_ch.data.action == prq_pkg::ActEnq) state_nxt = S_ENQ_R;
        else state_nxt = S_SCAN;
      end
      S_ENQ_R: state_nxt = S_ENQ_W;
      S_ENQ_W: begin
        // append: empty level takes head, else link from old tail
        if (!nonempty_r[app_lvl_r]) head_we = 1'b1;
        else link_we = 1'b1;
        tail_we = 1'b1;
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        if (lvl_done_r) state_nxt = S_OUT;
        else if (nonempty_r[lvl_r]) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_CMP;
      S_CMP: begin
        lvl_ra = lvl_r;
        if ({1'b0, draw} < thresh_r) state_nxt = S_DQ_R;
        else state_nxt = S_SCAN;
      end
      S_DQ_R: begin lvl_ra = lvl_r; state_nxt = S_DQ_L; end
      S_DQ_L: begin lvl_ra = lvl_r; link_ra = head_rd; state_nxt = S_DQ_W; end
      S_DQ_W: begin
        head_wa = lvl_r; head_wd = link_rd;
        head_we = (head_rd != tail_rd);
        lvl_ra = cur_pri_r;
        state_nxt = S_RQ_R;
      end
      S_RQ_R: state_nxt = S_ENQ_W;
      S_RQ_W: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thresh_r <= prq_pkg::ThreshReset;
      rnd_r <= prq_pkg::SeedReset;
      cur_pri_r <= '0;
      cur_r <= '0;
      nonempty_r <= '0;
      out_v_r <= 1'b0;
      lvl_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          prq_pkg::CfgThresh: thresh_r <= cfg_wdata[15:0];
          prq_pkg::CfgSeed: rnd_r <= cfg_wdata;
          prq_pkg::CfgBoot: cur_pri_r <= cfg_wdata[LW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_acc) begin
          prev_r <= cur_r;
          app_tid_r <= in_ch.data.thread_id[TW-1:0];
          app_lvl_r <= clamp_lvl;
          lvl_r <= LW'(prq_pkg::Levels - 1);
          lvl_done_r <= 1'b0;
          res_r.switched <= 1'b0;
        end
        S_ENQ_W: nonempty_r[app_lvl_r] <= 1'b1;
        S_SCAN: if (!lvl_done_r && !nonempty_r[lvl_r]) begin
          if (lvl_r == '0) lvl_done_r <= 1'b1;
          lvl_r <= lvl_r - 1'b1;
        end
        S_MUL: prod_r <= rnd_r * prq_pkg::LcgMul;
        S_CMP: begin
          rnd_r <= rnd_new;
          if (!({1'b0, draw} < thresh_r)) begin
            if (lvl_r == '0) lvl_done_r <= 1'b1;
            lvl_r <= lvl_r - 1'b1;
          end
        end
        S_DQ_W: begin
          pick_r <= head_rd;
          if (head_rd == tail_rd) nonempty_r[lvl_r] <= 1'b0;
          app_tid_r <= cur_r;
          app_lvl_r <= cur_pri_r;
        end
        S_RQ_R: begin
          cur_r <= pick_r;
          cur_pri_r <= lvl_r;
          res_r.switched <= 1'b1;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          res_r.running_thread <= cur_r;
          res_r.previous_thread <= prev_r;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == S_IDLE) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(res_r)) else $error("result dropped");
  a_enq_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.switched |-> res_r.running_thread == res_r.previous_thread)
    else $error("thread changed without switch");
`endif
endmodule
